@@ hdl/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic sweep;
  } lkvc_cmd_t;

  typedef struct packed {
    logic last;
    logic is_put;
    logic hit;
    logic slot_ok;
  } lkvc_sts_t;

endpackage

@@ hdl/lkvc_ram.sv @@
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lkvc_ctrl.sv @@
module lkvc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lkvc_pkg::lkvc_sts_t sts_i,
  output lkvc_pkg::lkvc_cmd_t cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_DECIDE,
    ST_SWEEP,
    ST_SWEEP_TAIL,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last) begin
          state_d = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!sts_i.is_put && !sts_i.hit) begin
          state_d = ST_RESP;
        end else if (!sts_i.slot_ok) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.last) begin
          state_d = ST_SWEEP_TAIL;
        end
      end
      ST_SWEEP_TAIL: state_d = sts_i.is_put ? ST_IDLE : ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
      done_q  <= (state_d == ST_RESP);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

@@ hdl/lkvc_dp.sv @@
module lkvc_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lkvc_pkg::lkvc_cmd_t         cmd_i,
  output lkvc_pkg::lkvc_sts_t         sts_o,
  input  logic                        operation_i,
  input  logic [lkvc_pkg::KEY_W-1:0]  key_i,
  input  logic [lkvc_pkg::DATA_W-1:0] value_i,
  input  logic                        cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data_i,
  output logic                        found_o,
  output logic [lkvc_pkg::DATA_W-1:0] data_o
);

  localparam int unsigned AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  // Request word
  logic                        op_q;
  logic [lkvc_pkg::KEY_W-1:0]  key_q;
  logic [lkvc_pkg::DATA_W-1:0] val_q;

  // Table control
  logic [ENTRIES-1:0]         valid_q;
  logic [CW-1:0]              used_q;
  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]              cnt_q;

  // Scan results
  logic                        cmp_vld_q;
  logic [AW-1:0]               cmp_idx_q;
  logic                        hit_q;
  logic [AW-1:0]               hit_slot_q;
  logic [AW-1:0]               hit_rank_q;
  logic [lkvc_pkg::DATA_W-1:0] hit_data_q;
  logic                        vic_vld_q;
  logic [AW-1:0]               vic_slot_q;
  logic [AW-1:0]               vic_rank_q;
  logic                        free_vld_q;
  logic [AW-1:0]               free_slot_q;

  // Rank sweep
  logic          wb_vld_q;
  logic [AW-1:0] wb_idx_q;
  logic [AW-1:0] slot_q;
  logic [AW-1:0] thr_q;
  logic          all_q;

  logic [AW-1:0]               rd_addr;
  logic [lkvc_pkg::KEY_W-1:0]  key_rd;
  logic [lkvc_pkg::DATA_W-1:0] data_rd;
  logic [AW-1:0]               rank_rd;

  logic                        cmp_v, hit_take, vic_take, free_take;
  logic [CMPW-1:0]             cap_ext, eff_cap;
  logic                        need_evict, evict_en, put_miss, slot_ok;
  logic [AW-1:0]               tgt_slot;
  logic                        wb_slot, wb_inc, rank_we;
  logic [AW-1:0]               rank_wdata;
  logic                        key_we, data_we;

  assign rd_addr = cnt_q[AW-1:0];

  lkvc_ram #(.WIDTH(lkvc_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (tgt_slot),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rd)
  );

  lkvc_ram #(.WIDTH(lkvc_pkg::DATA_W), .DEPTH(ENTRIES)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (tgt_slot),
    .wdata_i (val_q),
    .raddr_i (rd_addr),
    .rdata_o (data_rd)
  );

  lkvc_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (wb_idx_q),
    .wdata_i (rank_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rank_rd)
  );

  // Compare stage
  assign cmp_v     = valid_q[cmp_idx_q];
  assign hit_take  = cmp_v && (key_rd == key_q) && !hit_q;
  assign vic_take  = cmp_v && (!vic_vld_q || (rank_rd > vic_rank_q));
  assign free_take = !cmp_v && !free_vld_q;

  // Placement decision
  always_comb begin
    cap_ext = CMPW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign need_evict = (CMPW'(used_q) >= eff_cap);
  assign evict_en   = need_evict && vic_vld_q;
  assign put_miss   = (op_q == lkvc_pkg::OP_PUT) && !hit_q;
  assign slot_ok    = hit_q || evict_en || free_vld_q;
  assign tgt_slot   = hit_q ? hit_slot_q : (evict_en ? vic_slot_q : free_slot_q);

  assign key_we  = cmd_i.commit && put_miss;
  assign data_we = cmd_i.commit && (op_q == lkvc_pkg::OP_PUT);

  // Rank write-back: target goes to 0, younger (or all, on insert) age by one
  assign wb_slot    = (wb_idx_q == slot_q);
  assign wb_inc     = valid_q[wb_idx_q] && (all_q || (rank_rd < thr_q));
  assign rank_we    = wb_vld_q && (wb_slot || wb_inc);
  assign rank_wdata = wb_slot ? '0 : AW'(rank_rd + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      used_q     <= '0;
      cap_q      <= lkvc_pkg::CAP_RESET;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      wb_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      vic_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan;
      wb_vld_q  <= cmd_i.sweep;
      if (cmd_i.load || cmd_i.commit) begin
        cnt_q <= '0;
      end else if (cmd_i.scan || cmd_i.sweep) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.load) begin
        hit_q      <= 1'b0;
        vic_vld_q  <= 1'b0;
        free_vld_q <= 1'b0;
      end else if (cmp_vld_q) begin
        if (hit_take) begin
          hit_q <= 1'b1;
        end
        if (vic_take) begin
          vic_vld_q <= 1'b1;
        end
        if (free_take) begin
          free_vld_q <= 1'b1;
        end
      end
      if (cmd_i.commit && put_miss) begin
        valid_q[tgt_slot] <= 1'b1;
        if (!evict_en) begin
          used_q <= used_q + CW'(1);
        end
      end
      if (cfg_we_i) begin
        cap_q   <= cfg_data_i;
        valid_q <= '0;
        used_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_addr;
    wb_idx_q  <= rd_addr;
    if (cmd_i.load) begin
      op_q  <= operation_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (cmp_vld_q && !cmd_i.load) begin
      if (hit_take) begin
        hit_slot_q <= cmp_idx_q;
        hit_rank_q <= rank_rd;
        hit_data_q <= data_rd;
      end
      if (vic_take) begin
        vic_slot_q <= cmp_idx_q;
        vic_rank_q <= rank_rd;
      end
      if (free_take) begin
        free_slot_q <= cmp_idx_q;
      end
    end
    if (cmd_i.commit) begin
      slot_q <= tgt_slot;
      thr_q  <= hit_rank_q;
      all_q  <= !hit_q;
    end
  end

  assign sts_o.last    = (cnt_q == CW'(ENTRIES - 1));
  assign sts_o.is_put  = (op_q == lkvc_pkg::OP_PUT);
  assign sts_o.hit     = hit_q;
  assign sts_o.slot_ok = slot_ok;

  assign found_o = hit_q;
  assign data_o  = hit_q ? hit_data_q : '0;

endmodule

@@ hdl/lru_key_value_cache.sv @@
// A get miss raises done_o after a lookup scan; a get hit also runs a rank sweep first.
// A put keeps busy high through a lookup scan and a rank sweep and gives no word.
// One word at a time: no new start is taken while busy is high. The scan and the sweep
// each visit one entry per cycle.
// done_o pulses for one cycle; the receiver cannot stall it.
// Reset (async, rst_ni low): table empty, capacity 16; a capacity write also empties it.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic [lkvc_pkg::KEY_W-1:0]  key_i,
  input  logic [lkvc_pkg::DATA_W-1:0] value_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic [lkvc_pkg::DATA_W-1:0] data_o,
  input  logic                        cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data_i
);

  lkvc_pkg::lkvc_cmd_t cmd;
  lkvc_pkg::lkvc_sts_t sts;
  logic                busy_w;

  lkvc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy_w),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_w),
    .done_o  (done_o)
  );

  lkvc_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .found_o     (found_o),
    .data_o      (data_o)
  );

  assign busy = busy_w;

endmodule

@@ hdl/lkvc_checker.sv @@
module lkvc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic                        found_o,
  input logic [lkvc_pkg::DATA_W-1:0] data_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("done_o outside an operation");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("done_o longer than one cycle or no return to idle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (data_o == '0))
    else $error("miss word carries non-zero data");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .found_o (found_o),
  .data_o  (data_o)
);

@@ dv/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  localparam int ENTRIES = 16;
  localparam int SETTLE  = 2 * ENTRIES + 8;
  localparam int PHASE_ITEMS = 95;

  typedef struct packed {
    logic                        found;
    logic [lkvc_pkg::DATA_W-1:0] data;
  } lookup_word_t;

  class lru_shadow_cache;
    bit                          valid[ENTRIES];
    logic [lkvc_pkg::KEY_W-1:0]  keys[ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] vals[ENTRIES];
    int unsigned                 rank[ENTRIES];
    int unsigned                 used;
    int unsigned                 cap;
    lookup_word_t                lookups_due[$];
    int                          errors;

    function void set_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
      cap = c;
      if (cap < 1) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      foreach (valid[i]) valid[i] = 1'b0;
      used = 0;
    endfunction

    function int find_slot(logic [lkvc_pkg::KEY_W-1:0] k);
      foreach (valid[i])
        if (valid[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void promote(int s);
      int unsigned r;
      r = rank[s];
      foreach (valid[i])
        if (valid[i] && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function void fill(logic [lkvc_pkg::KEY_W-1:0] k, logic [lkvc_pkg::DATA_W-1:0] v);
      int          slot;
      int unsigned worst;
      slot = -1;
      worst = 0;
      if (used >= cap) begin
        foreach (valid[i])
          if (valid[i] && (slot < 0 || rank[i] > worst)) begin
            worst = rank[i];
            slot = i;
          end
        if (slot >= 0) begin
          valid[slot] = 1'b0;
          used--;
        end
      end
      if (slot < 0)
        foreach (valid[i])
          if (!valid[i] && slot < 0) slot = i;
      if (slot < 0) return;
      foreach (valid[i])
        if (valid[i]) rank[i]++;
      valid[slot] = 1'b1;
      keys[slot] = k;
      vals[slot] = v;
      rank[slot] = 0;
      used++;
    endfunction

    function void note_item(logic op, logic [lkvc_pkg::KEY_W-1:0] k,
                            logic [lkvc_pkg::DATA_W-1:0] v);
      int           s;
      lookup_word_t w;
      s = find_slot(k);
      if (op == lkvc_pkg::OP_GET) begin
        if (s >= 0) begin
          promote(s);
          w.found = 1'b1;
          w.data = vals[s];
        end else begin
          w.found = 1'b0;
          w.data = '0;
        end
        lookups_due.push_back(w);
      end else if (s >= 0) begin
        promote(s);
        vals[s] = v;
      end else begin
        fill(k, v);
      end
    endfunction

    function void check_word(logic f, logic [lkvc_pkg::DATA_W-1:0] d);
      lookup_word_t w;
      if (lookups_due.size() == 0) begin
        $error("unexpected word: found %0b data %h", f, d);
        errors++;
        return;
      end
      w = lookups_due.pop_front();
      if (f !== w.found) begin
        $error("found: expected %0b, got %0b", w.found, f);
        errors++;
      end
      if (d !== w.data) begin
        $error("data: expected %h, got %h", w.data, d);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni      = 1'b0;
  logic                        start       = 1'b0;
  logic                        busy;
  logic                        operation_i = lkvc_pkg::OP_GET;
  logic [lkvc_pkg::KEY_W-1:0]  key_i       = '0;
  logic [lkvc_pkg::DATA_W-1:0] value_i     = '0;
  logic                        done_o;
  logic                        found_o;
  logic [lkvc_pkg::DATA_W-1:0] data_o;
  logic                        cfg_we_i    = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0]  cfg_data_i  = '0;

  lru_shadow_cache shadow = new;

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .key_i      (key_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .found_o    (found_o),
    .data_o     (data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result first, then a new accept; done_o only comes while busy is high, so the two never share an edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) shadow.check_word(found_o, data_o);
      if (start && !busy) shadow.note_item(operation_i, key_i, value_i);
    end
  end

  task automatic send_item(logic op, logic [lkvc_pkg::KEY_W-1:0] k,
                           logic [lkvc_pkg::DATA_W-1:0] v);
    @(negedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    key_i <= k;
    value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic hold_off(int n);
    @(negedge clk_i);
    start <= 1'b0;
    operation_i <= 1'($urandom_range(0, 1));
    key_i <= $urandom;
    value_i <= $urandom;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
    hold_off(1);
    while (shadow.lookups_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    shadow.set_capacity(c);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n, bit with_gaps);
    logic [lkvc_pkg::KEY_W-1:0]  pool[24];
    logic [lkvc_pkg::KEY_W-1:0]  k;
    logic [lkvc_pkg::DATA_W-1:0] v;
    int                          span;
    span = int'(shadow.cap) + 3;
    if (span > 23) span = 23;
    foreach (pool[i]) pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      if (with_gaps && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 16));
      k = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, span)];
      v = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
      send_item($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, k, v);
    end
  endtask

  initial begin
    logic [lkvc_pkg::CAP_W-1:0] caps[7];
    caps = '{5'd31, 5'd16, 5'd5, 5'd1, 5'd3, 5'd0, 5'd16};
    caps[6] = lkvc_pkg::CAP_W'($urandom_range(1, 16));
    shadow.set_capacity(lkvc_pkg::CAP_RESET);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity: misses, hits, all-ones key and value, update in place
    send_item(lkvc_pkg::OP_GET, 32'h0, 32'h1234_5678);
    send_item(lkvc_pkg::OP_PUT, 32'h0, 32'h0);
    send_item(lkvc_pkg::OP_GET, 32'h0, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(lkvc_pkg::OP_GET, 32'h1, 32'h0);
    send_item(lkvc_pkg::OP_PUT, 32'h0, 32'hA5A5_A5A5);
    send_item(lkvc_pkg::OP_GET, 32'h0, 32'h0);

    // capacity of one: clean eviction
    write_capacity(5'd1);
    send_item(lkvc_pkg::OP_PUT, 32'h7, 32'h1);
    send_item(lkvc_pkg::OP_PUT, 32'h8, 32'h2);
    send_item(lkvc_pkg::OP_GET, 32'h7, 32'h0);
    send_item(lkvc_pkg::OP_GET, 32'h8, 32'h0);

    // zero acts as one
    write_capacity(5'd0);
    send_item(lkvc_pkg::OP_PUT, 32'h9, 32'h3);
    send_item(lkvc_pkg::OP_GET, 32'h9, 32'h0);
    send_item(lkvc_pkg::OP_PUT, 32'hA, 32'h4);
    send_item(lkvc_pkg::OP_GET, 32'h9, 32'h0);

    // a get refreshes recency, so the other entry is evicted
    write_capacity(5'd2);
    send_item(lkvc_pkg::OP_PUT, 32'hB, 32'h5);
    send_item(lkvc_pkg::OP_PUT, 32'hC, 32'h6);
    send_item(lkvc_pkg::OP_GET, 32'hB, 32'h0);
    send_item(lkvc_pkg::OP_PUT, 32'hD, 32'h7);
    send_item(lkvc_pkg::OP_GET, 32'hC, 32'h0);
    send_item(lkvc_pkg::OP_GET, 32'hB, 32'h0);

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      random_phase(PHASE_ITEMS, p != 6);
    end

    hold_off(1);
    while (shadow.lookups_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (shadow.lookups_due.size() != 0) begin
      $error("%0d lookup words never arrived", shadow.lookups_due.size());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
